// ===== rtl/far_pkg.sv =====
// package for the fraction add and reduce block: word types and shared widths
package far_pkg;

  localparam int FIELD_IN_BITS  = 31;
  localparam int FIELD_OUT_BITS = 63;

  typedef struct packed {
    logic [FIELD_IN_BITS-1:0] left_num;
    logic [FIELD_IN_BITS-1:0] left_den;
    logic [FIELD_IN_BITS-1:0] right_num;
    logic [FIELD_IN_BITS-1:0] right_den;
  } far_in_t;

  typedef struct packed {
    logic [FIELD_OUT_BITS-1:0] sum_num;
    logic [FIELD_OUT_BITS-1:0] sum_den;
  } far_out_t;

  // request and status between the sequencer and the divider
  typedef struct packed {
    logic start;
  } far_div_ctl_t;

  typedef struct packed {
    logic busy;
    logic done;
  } far_div_sts_t;

endpackage

// ===== rtl/far_divider.sv =====
// shared radix-2 restoring divider: one quotient bit per cycle
module far_divider #(
  parameter int W = 63
) (
  input  logic                 clk,
  input  logic                 rst,
  input  far_pkg::far_div_ctl_t ctl,
  input  logic [W-1:0]         dividend,
  input  logic [W-1:0]         divisor,
  output far_pkg::far_div_sts_t sts,
  output logic [W-1:0]         quot,
  output logic [W-1:0]         rem
);
  import far_pkg::*;

  localparam int CW = $clog2(W + 1);

  logic [CW-1:0] count;
  logic [W-1:0]  dvd;
  logic [W-1:0]  dvs;
  logic [W:0]    trial;
  logic [W:0]    shifted;
  logic          busy;
  logic          done;

  // shift in the next dividend bit and try a subtract
  always_comb begin
    shifted = {rem, dvd[W-1]};
    trial   = shifted - {1'b0, dvs};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      busy  <= 1'b0;
      done  <= 1'b0;
      count <= '0;
    end else begin
      done <= 1'b0;
      if (ctl.start && !busy) begin
        busy  <= 1'b1;
        count <= CW'(W);
        dvd   <= dividend;
        dvs   <= divisor;
        rem   <= '0;
        quot  <= '0;
      end else if (busy) begin
        dvd <= {dvd[W-2:0], 1'b0};
        if (!trial[W]) begin
          rem  <= trial[W-1:0];
          quot <= {quot[W-2:0], 1'b1};
        end else begin
          rem  <= shifted[W-1:0];
          quot <= {quot[W-2:0], 1'b0};
        end
        count <= count - 1'b1;
        if (count == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

  assign sts.busy = busy;
  assign sts.done = done;

  property p_done_after_busy;
    @(posedge clk) disable iff (rst) sts.done |-> $past(busy);
  endproperty
  a_done_after_busy: assert property (p_done_after_busy) else $error("done without work");

  property p_no_done_busy;
    @(posedge clk) disable iff (rst) sts.done |-> !busy;
  endproperty
  a_no_done_busy: assert property (p_no_done_busy) else $error("done while busy");

  property p_count_live;
    @(posedge clk) disable iff (rst) busy |-> count != '0;
  endproperty
  a_count_live: assert property (p_count_live) else $error("busy with zero count");

endmodule

// ===== rtl/fraction_add_reduce.sv =====
// top level: fraction add with lcm of denominators and gcd reduction of the sum
//
// Adds two fractions and returns the sum in lowest terms, one word in, one
// word out. All divisions and remainders go through one shared 63-bit restoring
// divider that retires one quotient bit per cycle. An item needs one division
// per Euclid step on the denominators, three for the lcm and the two scale
// factors, one per Euclid step on the sum, and two for the final quotients; the
// two 31x31 products of the scaled numerators and their add are registered in
// states of their own. The input stall is high from acceptance until the result
// word has been taken; the result is held in a register until the output stall
// is low. Zero denominators count as one; input bits at or above VALUE_BITS are
// ignored.
module fraction_add_reduce #(
  parameter int VALUE_BITS = 31
) (
  input  logic            clk,
  input  logic            rst,
  input  logic            in_valid,
  output logic            in_stall,
  input  far_pkg::far_in_t in_data,
  output logic            out_valid,
  input  logic            out_stall,
  output far_pkg::far_out_t out_data
);
  import far_pkg::*;

  localparam int W = FIELD_OUT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_G1, S_LCM, S_SCL, S_SCR, S_MUL, S_ADD,
    S_G2, S_QN, S_QD, S_OUT
  } state_t;

  state_t state;

  logic [VALUE_BITS-1:0] ln, ld, rn, rd;
  logic [W-1:0] x, y, common, num, fl, fr, pl, pr;
  logic         issued;

  logic [2*VALUE_BITS-1:0] prod_c, prod_l, prod_r;

  far_div_ctl_t div_ctl;
  far_div_sts_t div_sts;
  logic [W-1:0] div_a, div_b, div_q, div_r;

  far_divider #(.W(W)) u_div (
    .clk(clk), .rst(rst), .ctl(div_ctl), .dividend(div_a), .divisor(div_b),
    .sts(div_sts), .quot(div_q), .rem(div_r)
  );

  // value-width products for the lcm and the scaled numerators
  assign prod_c = div_q[VALUE_BITS-1:0] * rd;
  assign prod_l = fl[VALUE_BITS-1:0] * ln;
  assign prod_r = fr[VALUE_BITS-1:0] * rn;

  // operand selection for the shared divider
  always_comb begin
    div_a = x;
    div_b = y;
    unique case (state)
      S_LCM:   begin div_a = W'(ld); div_b = x; end
      S_SCL:   begin div_a = common; div_b = W'(ld); end
      S_SCR:   begin div_a = common; div_b = W'(rd); end
      S_QN:    begin div_a = num;    div_b = x; end
      S_QD:    begin div_a = common; div_b = x; end
      default: begin div_a = x;      div_b = y; end
    endcase
    div_ctl.start = !issued && (state == S_G1 || state == S_LCM || state == S_SCL ||
                    state == S_SCR || state == S_G2 || state == S_QN || state == S_QD);
  end

  // sequencer
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      issued    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      if (div_ctl.start) issued <= 1'b1;
      unique case (state)
        S_IDLE: begin
          if (in_valid) begin
            ln <= in_data.left_num[VALUE_BITS-1:0];
            rn <= in_data.right_num[VALUE_BITS-1:0];
            ld <= (in_data.left_den[VALUE_BITS-1:0] == '0) ? VALUE_BITS'(1)
                  : in_data.left_den[VALUE_BITS-1:0];
            rd <= (in_data.right_den[VALUE_BITS-1:0] == '0) ? VALUE_BITS'(1)
                  : in_data.right_den[VALUE_BITS-1:0];
            x  <= (in_data.left_den[VALUE_BITS-1:0] == '0) ? W'(1)
                  : W'(in_data.left_den[VALUE_BITS-1:0]);
            y  <= (in_data.right_den[VALUE_BITS-1:0] == '0) ? W'(1)
                  : W'(in_data.right_den[VALUE_BITS-1:0]);
            issued <= 1'b0;
            state  <= S_G1;
          end
        end
        S_G1, S_G2: begin
          if (issued && div_sts.done) begin
            x <= y;
            y <= div_r;
            issued <= 1'b0;
            if (div_r == '0) state <= (state == S_G1) ? S_LCM : S_QN;
          end
        end
        S_LCM: begin
          if (issued && div_sts.done) begin
            common <= W'(prod_c);
            issued <= 1'b0;
            state  <= S_SCL;
          end
        end
        S_SCL: begin
          if (issued && div_sts.done) begin
            fl <= div_q; issued <= 1'b0; state <= S_SCR;
          end
        end
        S_SCR: begin
          if (issued && div_sts.done) begin
            fr <= div_q; state <= S_MUL;
          end
        end
        S_MUL: begin
          pl    <= W'(prod_l);
          pr    <= W'(prod_r);
          state <= S_ADD;
        end
        S_ADD: begin
          num    <= pl + pr;
          issued <= 1'b0;
          // a zero sum reduces by the common denominator itself
          if (pl + pr == '0) begin
            x     <= common;
            y     <= '0;
            state <= S_QN;
          end else begin
            x     <= pl + pr;
            y     <= common;
            state <= S_G2;
          end
        end
        S_QN: begin
          if (issued && div_sts.done) begin
            out_data.sum_num <= div_q; issued <= 1'b0; state <= S_QD;
          end
        end
        S_QD: begin
          if (issued && div_sts.done) begin
            out_data.sum_den <= div_q;
            out_valid <= 1'b1;
            state <= S_OUT;
          end
        end
        S_OUT: begin
          if (!out_stall) begin
            out_valid <= 1'b0;
            state     <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  assign in_stall = (state != S_IDLE);

  property p_out_only_done;
    @(posedge clk) disable iff (rst) out_valid |-> state == S_OUT;
  endproperty
  a_out_only_done: assert property (p_out_only_done) else $error("result outside output");

  property p_den_nonzero;
    @(posedge clk) disable iff (rst) out_valid |-> out_data.sum_den != '0;
  endproperty
  a_den_nonzero: assert property (p_den_nonzero) else $error("zero denominator");

  property p_div_idle_start;
    @(posedge clk) disable iff (rst) div_ctl.start |-> !div_sts.busy;
  endproperty
  a_div_idle_start: assert property (p_div_idle_start) else $error("divider restarted");

endmodule

// ===== tb/testbench.sv =====
// testbench for fraction_add_reduce: random and directed fraction sums checked against a predictor
`timescale 1ns / 1ps

module testbench;
  import far_pkg::*;

  localparam int VBITS = 31;

  // scoreboard: predicts reduced sums and holds them until the block answers
  class sum_board;
    far_out_t sums_due[$];
    int errors;
    int checked;

    function bit [62:0] gcd63(bit [62:0] x, bit [62:0] y);
      bit [62:0] r;
      while (y != 0) begin
        r = x % y;
        x = y;
        y = r;
      end
      return x;
    endfunction

    // one line per mismatch, counted
    task report_err(string what, bit [62:0] want, bit [62:0] got);
      $display("error at %0t: %s expected %0d got %0d", $realtime, what, want, got);
      errors++;
    endtask

    function void note_word(far_in_t w);
      bit [62:0] ln, ld, rn, rd, g, common, num, red;
      far_out_t e;
      ln = 63'(w.left_num[VBITS-1:0]);
      ld = 63'(w.left_den[VBITS-1:0]);
      rn = 63'(w.right_num[VBITS-1:0]);
      rd = 63'(w.right_den[VBITS-1:0]);
      if (ld == 0) ld = 1;
      if (rd == 0) rd = 1;
      g = gcd63(ld, rd);
      common = ld / g * rd;
      num = (common / ld) * ln + (common / rd) * rn;
      red = gcd63(num, common);
      e.sum_num = num / red;
      e.sum_den = common / red;
      sums_due.push_back(e);
    endfunction

    task check_word(far_out_t got);
      far_out_t e;
      checked++;
      if (sums_due.size() == 0) begin
        report_err("result word with nothing expected", 0, got.sum_num);
        return;
      end
      e = sums_due.pop_front();
      if (got.sum_num !== e.sum_num) report_err("sum_num", e.sum_num, got.sum_num);
      if (got.sum_den !== e.sum_den) report_err("sum_den", e.sum_den, got.sum_den);
    endtask
  endclass

  logic clk = 0;
  logic rst = 1;
  logic in_valid = 0;
  logic in_stall;
  far_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 1;
  far_out_t out_data;
  int fail_count = 0;
  sum_board board = new();

  fraction_add_reduce dut (
    .clk(clk), .rst(rst), .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data)
  );

  always begin
    #2 clk = 1;
    #2 clk = 0;
  end

  // send one word after a random gap
  task automatic send_word(far_in_t w);
    int gap;
    gap = $urandom_range(0, 10);
    if (gap != 0) begin
      in_valid <= 0;
      repeat (gap) @(negedge clk);
    end
    in_data <= w;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    board.note_word(w);
    @(negedge clk);
  endtask

  function automatic bit [30:0] rand_val();
    bit [30:0] v;
    case ($urandom_range(0, 5))
      0: v = $urandom_range(0, 15);
      1: v = $urandom_range(0, 1000);
      2: v = 31'($urandom) >> $urandom_range(0, 30);
      3: v = 31'($urandom_range(1, 64)) * 31'($urandom_range(1, 4096));
      default: v = 31'($urandom);
    endcase
    return v;
  endfunction

  // result side: random stall before each word, check on each accepted word
  initial begin
    int gap;
    out_stall = 1;
    @(negedge clk);
    while (rst) @(negedge clk);
    forever begin
      gap = $urandom_range(0, 10);
      if (gap != 0) begin
        out_stall <= 1;
        repeat (gap) @(negedge clk);
      end
      out_stall <= 0;
      do @(posedge clk); while (!out_valid);
      board.check_word(out_data);
      @(negedge clk);
    end
  end

  localparam bit [30:0] MAXV = 31'h7fffffff;

  // stimulus
  initial begin
    far_in_t w;
    bit [30:0] dir [8];
    dir = '{0, 1, 2, 3, MAXV, MAXV - 1, 31'h40000000, 31'h55555555};
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst <= 0;
    // directed: extremes, zero sums, zero denominators, coprime and shared factors
    for (int i = 0; i < 8; i++) begin
      w.left_num = dir[i]; w.left_den = dir[7 - i];
      w.right_num = dir[(i + 3) % 8]; w.right_den = dir[(i + 5) % 8];
      send_word(w);
    end
    send_word('{0, 0, 0, 0});
    send_word('{0, MAXV, 0, MAXV - 1});
    send_word('{MAXV, MAXV, MAXV, MAXV - 1});
    send_word('{MAXV, 1, MAXV, 1});
    send_word('{1, 2, 1, 2});
    send_word('{1, 6, 1, 3});
    send_word('{MAXV, MAXV - 2, MAXV - 1, MAXV - 3});
    send_word('{31'd1836311903, 31'd1134903170, 31'd701408733, 31'd433494437});
    send_word('{5, 0, 7, 31'h40000000});
    // hold off until every expected word is back
    in_valid <= 0;
    while (board.sums_due.size() != 0) @(negedge clk);
    for (int n = 0; n < 1170; n++) begin
      w.left_num = rand_val();
      w.left_den = rand_val();
      w.right_num = rand_val();
      w.right_den = rand_val();
      if (n == 600) begin
        in_valid <= 0;
        while (board.sums_due.size() != 0) @(negedge clk);
      end
      send_word(w);
    end
    in_valid <= 0;
    while (board.sums_due.size() != 0) @(negedge clk);
    repeat (100) @(negedge clk);
    fail_count += board.errors;
    $display("covered %0d result words: extremes, zero sums, zero denominators, random sizes",
             board.checked);
    if (fail_count == 0)
      $display("fraction_add_reduce: match");
    else
      $display("fraction_add_reduce: mismatch");
    $finish;
  end

  // time limit
  initial begin
    #200000000;
    $display("timeout with %0d words outstanding", board.sums_due.size());
    $display("fraction_add_reduce: mismatch");
    $finish;
  end
endmodule

// ===== filelist.f =====
rtl/far_pkg.sv
rtl/far_divider.sv
rtl/fraction_add_reduce.sv
tb/testbench.sv
